[src/rtcp_pkg.sv]
// ----------------------------------------------------------------------------
// RTCP parser package
// Shared codes, field widths and the result record of the compound parser.
// ----------------------------------------------------------------------------
package rtcp_pkg;

  localparam logic [3:0] EV_HEADER   = 4'd0;
  localparam logic [3:0] EV_REPORT   = 4'd1;
  localparam logic [3:0] EV_ITEM     = 4'd2;
  localparam logic [3:0] EV_SBYTE    = 4'd3;
  localparam logic [3:0] EV_BSRC     = 4'd4;
  localparam logic [3:0] EV_BBYTE    = 4'd5;
  localparam logic [3:0] EV_AWORD    = 4'd6;
  localparam logic [3:0] EV_ABYTE    = 4'd7;
  localparam logic [3:0] EV_PEND     = 4'd8;
  localparam logic [3:0] EV_ERROR    = 4'd9;

  localparam logic [2:0] ERR_SHORT   = 3'd0;
  localparam logic [2:0] ERR_VERSION = 3'd1;
  localparam logic [2:0] ERR_OVERRUN = 3'd2;
  localparam logic [2:0] ERR_ITEM    = 3'd3;
  localparam logic [2:0] ERR_PRIV    = 3'd4;
  localparam logic [2:0] ERR_REASON  = 3'd5;

  localparam logic [7:0] PT_SR   = 8'd200;
  localparam logic [7:0] PT_RR   = 8'd201;
  localparam logic [7:0] PT_SDES = 8'd202;
  localparam logic [7:0] PT_BYE  = 8'd203;
  localparam logic [7:0] PT_APP  = 8'd204;
  localparam logic [7:0] SDES_PRIV = 8'd8;

  localparam logic [3:0] PH_HDR   = 4'd0;
  localparam logic [3:0] PH_RPT   = 4'd1;
  localparam logic [3:0] PH_SSRC  = 4'd2;
  localparam logic [3:0] PH_TYPE  = 4'd3;
  localparam logic [3:0] PH_LEN   = 4'd4;
  localparam logic [3:0] PH_PRIV  = 4'd5;
  localparam logic [3:0] PH_DATA  = 4'd6;
  localparam logic [3:0] PH_PAD   = 4'd7;
  localparam logic [3:0] PH_BSRC  = 4'd8;
  localparam logic [3:0] PH_BLEN  = 4'd9;
  localparam logic [3:0] PH_BDATA = 4'd10;
  localparam logic [3:0] PH_AWORD = 4'd11;
  localparam logic [3:0] PH_ADATA = 4'd12;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [3:0]  ev;
    logic [7:0]  ptype;
    logic [4:0]  hcount;
    logic [4:0]  blk;
    logic [2:0]  wrd;
    logic [31:0] value;
    logic [31:0] ssrc;
    logic [7:0]  kind;
    logic [7:0]  ilen;
    logic [7:0]  plen;
    logic [2:0]  ecode;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } group_t;

endpackage

[src/rtcp_front.sv]
// ----------------------------------------------------------------------------
// RTCP parser front end
// Parses one byte per cycle unless stalled and produces a group of up to two results.
// ----------------------------------------------------------------------------
module rtcp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                grp_valid,
  output rtcp_pkg::group_t    grp,
  input  logic                grp_stall
);
  import rtcp_pkg::*;

  logic [3:0]  phase, phase_next;
  logic [1:0]  hseen, hseen_next;
  logic [17:0] left, left_next;
  logic [31:0] gather, gather_next;
  logic [7:0]  ctype, ctype_next;
  logic [4:0]  ccount, ccount_next;
  logic [4:0]  blk, blk_next;
  logic [2:0]  wrd, wrd_next;
  logic [31:0] cssrc, cssrc_next;
  logic [7:0]  ileft, ileft_next;
  logic [7:0]  ikind, ikind_next;
  logic [7:0]  hlen, hlen_next;
  logic [7:0]  hpre, hpre_next;
  logic        halted, halted_next;
  logic        skip, skip_next;

  res_t        rs [MAX_RES];
  logic [1:0]  n;
  group_t      g;
  logic        take;

  assign in_stall = grp_valid && grp_stall;
  assign take     = in_valid && !in_stall;

  function automatic res_t base(logic [3:0] ev, logic [7:0] t, logic [4:0] c);
    res_t r;
    r = '0;
    r.ev = ev;
    r.ptype = t;
    r.hcount = c;
    return r;
  endfunction

  always_comb begin
    logic [31:0] wg;
    logic [17:0] rem;
    logic        wdone;
    logic [15:0] words;
    logic [2:0]  heads;
    logic [2:0]  wi;
    res_t        r;
    phase_next = phase; hseen_next = hseen; left_next = left;
    ctype_next = ctype; ccount_next = ccount; blk_next = blk; wrd_next = wrd;
    cssrc_next = cssrc; ileft_next = ileft; ikind_next = ikind;
    hlen_next = hlen; hpre_next = hpre; halted_next = halted; skip_next = skip;
    rs[0] = '0; rs[1] = '0; rs[2] = '0;
    n = 2'd0;
    wg = {gather[23:0], in_byte};
    gather_next = gather;
    rem = '0; wdone = 1'b0; words = '0; heads = '0; wi = '0; r = '0;
    if (halted) begin
      if (in_last) begin
        halted_next = 1'b0; phase_next = PH_HDR; hseen_next = '0; skip_next = 1'b0;
      end
    end else begin
      gather_next = wg;
      if (phase == PH_HDR && !skip) begin
        if (hseen == 2'd0) ccount_next = in_byte[4:0];
        if (hseen == 2'd1) ctype_next = in_byte;
        if (hseen != 2'd3) begin
          if (in_last) begin
            rs[0] = base(EV_ERROR, 8'd0, 5'd0);
            rs[0].ecode = ERR_SHORT;
            n = 2'd1;
          end else begin
            hseen_next = hseen + 2'd1;
          end
        end else begin
          hseen_next = '0;
          if (wg[31:30] != 2'd2) begin
            rs[0] = base(EV_ERROR, ctype, ccount);
            rs[0].ecode = ERR_VERSION;
            n = 2'd1;
            if (!in_last) halted_next = 1'b1;
          end else begin
            words = wg[15:0];
            rs[0] = base(EV_HEADER, ctype, ccount);
            rs[0].value = {16'd0, words};
            n = 2'd1;
            left_next = {words, 2'b00};
            blk_next = '0; wrd_next = '0; skip_next = 1'b0;
            case (ctype)
              PT_SR, PT_RR: phase_next = PH_RPT;
              PT_SDES: begin
                phase_next = PH_SSRC;
                if (ccount == 5'd0) skip_next = 1'b1;
              end
              PT_BYE:  phase_next = (ccount == 5'd0) ? PH_BLEN : PH_BSRC;
              PT_APP:  phase_next = PH_AWORD;
              default: begin
                phase_next = PH_HDR; skip_next = 1'b1;
              end
            endcase
            if (words == 16'd0) begin
              rs[1] = base(EV_PEND, ctype, ccount);
              n = 2'd2;
              phase_next = PH_HDR; skip_next = 1'b0;
            end else if (in_last) begin
              rs[1] = base(EV_ERROR, ctype, ccount);
              rs[1].ecode = ERR_OVERRUN;
              n = 2'd2;
            end
          end
        end
      end else begin
        rem = (left == '0) ? '0 : left - 18'd1;
        wdone = (rem[1:0] == 2'b00);
        r = base(EV_ITEM, ctype, ccount);
        r.blk = blk; r.ssrc = cssrc; r.kind = ikind; r.ilen = hlen; r.plen = hpre;
        if (!skip) begin
          case (phase)
            PH_RPT: if (wdone) begin
              rs[0] = base(EV_REPORT, ctype, ccount);
              rs[0].blk = blk; rs[0].wrd = wrd; rs[0].value = wg;
              n = 2'd1;
              wi = wrd + 3'd1;
              heads = (blk != '0 || ctype == PT_SR) ? 3'd6 : 3'd1;
              wrd_next = wi;
              if (wi >= heads) begin
                wrd_next = '0;
                if (blk >= ccount) skip_next = 1'b1;
                else blk_next = blk + 5'd1;
              end
            end
            PH_SSRC: if (wdone) begin
              cssrc_next = wg; phase_next = PH_TYPE;
            end
            PH_TYPE: begin
              if (in_byte == 8'd0) begin
                if (wdone) begin
                  if ({1'b0, blk} + 6'd1 >= {1'b0, ccount}) skip_next = 1'b1;
                  else begin
                    blk_next = blk + 5'd1; phase_next = PH_SSRC;
                  end
                end else phase_next = PH_PAD;
              end else begin
                ikind_next = in_byte; phase_next = PH_LEN;
              end
            end
            PH_PAD: if (wdone) begin
              if ({1'b0, blk} + 6'd1 >= {1'b0, ccount}) skip_next = 1'b1;
              else begin
                blk_next = blk + 5'd1; phase_next = PH_SSRC;
              end
            end
            PH_LEN: begin
              hlen_next = in_byte; hpre_next = '0;
              r.ilen = in_byte; r.plen = '0;
              if ({10'd0, in_byte} > rem) begin
                rs[0] = base(EV_ERROR, ctype, ccount);
                rs[0].ecode = ERR_ITEM; n = 2'd1; skip_next = 1'b1;
              end else if (in_byte == 8'd0) begin
                rs[0] = r; n = 2'd1; phase_next = PH_TYPE;
              end else if (ikind == SDES_PRIV) begin
                phase_next = PH_PRIV;
              end else begin
                rs[0] = r; n = 2'd1; ileft_next = in_byte; phase_next = PH_DATA;
              end
            end
            PH_PRIV: begin
              if ({1'b0, in_byte} + 9'd1 > {1'b0, hlen}) begin
                rs[0] = base(EV_ERROR, ctype, ccount);
                rs[0].ecode = ERR_PRIV; n = 2'd1; skip_next = 1'b1;
              end else begin
                hpre_next = in_byte;
                r.plen = in_byte;
                rs[0] = r; n = 2'd1;
                ileft_next = hlen - 8'd1;
                phase_next = (hlen == 8'd1) ? PH_TYPE : PH_DATA;
              end
            end
            PH_DATA: begin
              r.ev = EV_SBYTE; r.value = {24'd0, in_byte};
              rs[0] = r; n = 2'd1;
              ileft_next = ileft - 8'd1;
              if (ileft == 8'd1) phase_next = PH_TYPE;
            end
            PH_BSRC: if (wdone) begin
              rs[0] = base(EV_BSRC, ctype, ccount);
              rs[0].blk = blk; rs[0].value = wg; n = 2'd1;
              if ({1'b0, blk} + 6'd1 >= {1'b0, ccount}) phase_next = PH_BLEN;
              else blk_next = blk + 5'd1;
            end
            PH_BLEN: begin
              hlen_next = in_byte;
              if ({10'd0, in_byte} > rem) begin
                rs[0] = base(EV_ERROR, ctype, ccount);
                rs[0].ecode = ERR_REASON; n = 2'd1; skip_next = 1'b1;
              end else if (in_byte == 8'd0) skip_next = 1'b1;
              else begin
                ileft_next = in_byte; phase_next = PH_BDATA;
              end
            end
            PH_BDATA: begin
              rs[0] = base(EV_BBYTE, ctype, ccount);
              rs[0].value = {24'd0, in_byte}; rs[0].ilen = hlen; n = 2'd1;
              ileft_next = ileft - 8'd1;
              if (ileft == 8'd1) skip_next = 1'b1;
            end
            PH_AWORD: if (wdone) begin
              rs[0] = base(EV_AWORD, ctype, ccount);
              rs[0].wrd = wrd; rs[0].value = wg; n = 2'd1;
              wrd_next = wrd + 3'd1;
              if (wrd + 3'd1 >= 3'd2) phase_next = PH_ADATA;
            end
            PH_ADATA: begin
              rs[0] = base(EV_ABYTE, ctype, ccount);
              rs[0].value = {24'd0, in_byte}; n = 2'd1;
            end
            default: skip_next = 1'b1;
          endcase
        end
        left_next = rem;
        if (rem == '0) begin
          rs[n] = base(EV_PEND, ctype_next, ccount_next);
          n = n + 2'd1;
          phase_next = PH_HDR; skip_next = 1'b0; hseen_next = '0;
        end else if (in_last) begin
          rs[n] = base(EV_ERROR, ctype_next, ccount_next);
          rs[n].ecode = ERR_OVERRUN;
          n = n + 2'd1;
        end
      end
      if (in_last) begin
        phase_next = PH_HDR; hseen_next = '0; skip_next = 1'b0; left_next = '0;
      end
    end
    if (n != 2'd0) rs[n - 2'd1].last = 1'b1;
    g.cnt = n; g.r0 = rs[0]; g.r1 = rs[1]; g.r2 = rs[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR; hseen <= '0; left <= '0; gather <= '0; ctype <= '0;
      ccount <= '0; blk <= '0; wrd <= '0; cssrc <= '0; ileft <= '0;
      ikind <= '0; hlen <= '0; hpre <= '0; halted <= 1'b0; skip <= 1'b0;
      grp_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next; hseen <= hseen_next; left <= left_next;
        gather <= gather_next; ctype <= ctype_next; ccount <= ccount_next;
        blk <= blk_next; wrd <= wrd_next; cssrc <= cssrc_next;
        ileft <= ileft_next; ikind <= ikind_next; hlen <= hlen_next;
        hpre <= hpre_next; halted <= halted_next; skip <= skip_next;
        grp_valid <= (n != 2'd0);
      end else if (!grp_stall) begin
        grp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) grp <= g;
  end

endmodule

[src/rtcp_back.sv]
// ----------------------------------------------------------------------------
// RTCP parser back end
// Queues result groups and sends their results one per transaction.
// ----------------------------------------------------------------------------
module rtcp_back #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             grp_valid,
  input  rtcp_pkg::group_t grp,
  output logic             grp_stall,
  output logic             out_valid,
  output rtcp_pkg::res_t   out_res,
  input  logic             out_stall
);
  import rtcp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  group_t         mem [DEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    fill;
  logic [1:0]     sel;
  logic           push, pop, send;
  group_t         head;

  assign head      = mem[rp];
  assign grp_stall = (fill == (AW+1)'(DEPTH));
  assign push      = grp_valid && !grp_stall;
  assign out_valid = (fill != '0);
  assign send      = out_valid && !out_stall;
  assign pop       = send && (sel + 2'd1 == head.cnt);

  always_comb begin
    case (sel)
      2'd0:    out_res = head.r0;
      2'd1:    out_res = head.r1;
      default: out_res = head.r2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0; sel <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      if (send) sel <= pop ? 2'd0 : sel + 2'd1;
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= grp;
  end

endmodule

[src/rtcp_compound_packet_parser_unit.sv]
// ----------------------------------------------------------------------------
// RTCP compound packet parser
// Results are registered in the front end, then queued in the back end.
// Throughput: one byte per cycle; results leave one per cycle while out_stall
// is low, so bytes giving several results fill the queue and may stall input.
// Reset: synchronous, returns to header parsing with an empty queue.
// ----------------------------------------------------------------------------
module rtcp_compound_packet_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_res,
  output logic [7:0]  packet_type,
  output logic [4:0]  header_count,
  output logic [4:0]  block_number,
  output logic [2:0]  word_number,
  output logic [31:0] field_value,
  output logic [31:0] source_id,
  output logic [7:0]  item_kind,
  output logic [7:0]  item_length,
  output logic [7:0]  prefix_length,
  output logic [2:0]  error_code,
  output logic        last_of_run
);
  import rtcp_pkg::*;

  logic   gv, gs;
  group_t g;
  res_t   r;

  rtcp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(data_byte), .in_last(last_byte),
    .grp_valid(gv), .grp(g), .grp_stall(gs)
  );

  rtcp_back #(.DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .grp_valid(gv), .grp(g), .grp_stall(gs),
    .out_valid(out_valid), .out_res(r), .out_stall(out_stall)
  );

  assign event_res     = r.ev;
  assign packet_type   = r.ptype;
  assign header_count  = r.hcount;
  assign block_number  = r.blk;
  assign word_number   = r.wrd;
  assign field_value   = r.value;
  assign source_id     = r.ssrc;
  assign item_kind     = r.kind;
  assign item_length   = r.ilen;
  assign prefix_length = r.plen;
  assign error_code    = r.ecode;
  assign last_of_run   = r.last;

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= EV_ERROR) else $error("event code out of range");
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_ERROR) |-> error_code <= ERR_REASON)
    else $error("bad error code");
  a_last_advance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |=> out_valid)
    else $error("result group broken");

endmodule
